@@ hw/rtl/hbt_pkg.sv @@
// Package: widths, key layout and mod-25 reduction for the Hill block transform.
package hbt_pkg;

  localparam int BLOCK_SIZE = 3;
  localparam int SYM_W      = 5;
  localparam int KEY_DIM    = 3;
  localparam int DIGIT_W    = 5;
  localparam int KEY_W      = KEY_DIM * KEY_DIM * DIGIT_W;
  localparam logic [KEY_W-1:0] KEY_RESET = 45'h100_0010_0001;

  // Dot product of up to four 5-bit by 5-bit terms stays below 4096.
  localparam int SUM_W       = 12;
  localparam int MODULUS     = 25;
  // floor(x * 1311 / 2**15) == floor(x / 25) exactly for x < 4096.
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP = 11'd1311;

  function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_W-1:0] key,
                                                   input int row, input int col);
    logic [KEY_W-1:0] shifted;
    shifted = '0;
    if (row < KEY_DIM && col < KEY_DIM) begin
      shifted = key >> (DIGIT_W * (KEY_DIM * row + col));
    end
    return shifted[DIGIT_W-1:0];
  endfunction

  function automatic logic [SYM_W-1:0] mod25(input logic [SUM_W-1:0] x);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         q;
    logic [SUM_W-1:0]         r;
    prod = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(RECIP);
    q    = SUM_W'(prod >> RECIP_SHIFT);
    r    = x - q * SUM_W'(MODULUS);
    return r[SYM_W-1:0];
  endfunction

endpackage

@@ hw/rtl/hbt_if.sv @@
// Stream interfaces: input symbols and output plaintext symbols.
interface hbt_in_if;
  logic                    valid;
  logic                    ready;
  logic [hbt_pkg::SYM_W-1:0] symbol;
  logic                    end_of_message;

  modport source (output valid, output symbol, output end_of_message, input ready);
  modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

interface hbt_out_if;
  logic                    valid;
  logic                    ready;
  logic [hbt_pkg::SYM_W-1:0] plain_symbol;
  logic                    last_of_run;

  modport source (output valid, output plain_symbol, output last_of_run, input ready);
  modport sink   (input valid, input plain_symbol, input last_of_run, output ready);
endinterface

@@ hw/rtl/hill_block_transform_mod25_core.sv @@
// Top level: Hill cipher block transform over a 25-letter alphabet.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------
//  in_ch     | in  | valid/ready   | symbol[4:0], end_of_message
//  out_ch    | out | valid/ready   | plain_symbol[4:0], last_of_run
//  cfg       | in  | cfg_write     | cfg_data[44:0] (key matrix, row-major)
//
// One symbol per cycle is taken while in_ch.ready is high. A block is latched into
// the job register on its closing transaction; once the result buffer is free, the
// key product and mod-25 land in it, and it drains one result per cycle while
// out_ch.ready is high. Output stalls back up through the job register.
// rst clears fill count, valid flags and loads the identity key.
module hill_block_transform_mod25_core #(
  parameter int BLOCK_SIZE = hbt_pkg::BLOCK_SIZE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [hbt_pkg::KEY_W-1:0] cfg_data,
  hbt_in_if.sink                    in_ch,
  hbt_out_if.source                 out_ch
);
  import hbt_pkg::*;

  localparam int FW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  logic [KEY_W-1:0] key;
  logic [FW-1:0]    fill_count;
  logic [SYM_W-1:0] held [BLOCK_SIZE-1];

  logic             job_valid;
  logic             job_full;
  logic [FW-1:0]    job_last;
  logic [SYM_W-1:0] job_sym [BLOCK_SIZE];

  logic             run_valid;
  logic [FW-1:0]    run_idx;
  logic [FW-1:0]    run_last;
  logic [SYM_W-1:0] run_val [BLOCK_SIZE];

  logic [SYM_W-1:0] dot [BLOCK_SIZE];

  logic accept, completes, makes_job, run_free, job_move, out_take, run_at_last;

  assign accept      = in_ch.valid && in_ch.ready;
  assign completes   = (fill_count == FW'(BLOCK_SIZE - 1));
  assign makes_job   = completes || in_ch.end_of_message;
  assign run_at_last = (run_idx == run_last);
  assign out_take    = out_ch.valid && out_ch.ready;
  assign run_free    = !run_valid || (out_ch.ready && run_at_last);
  assign job_move    = job_valid && run_free;

  assign in_ch.ready         = !job_valid || run_free;
  assign out_ch.valid        = run_valid;
  assign out_ch.plain_symbol = run_val[run_idx];
  assign out_ch.last_of_run  = run_at_last;

  hbt_matvec #(.BLOCK_SIZE(BLOCK_SIZE)) u_matvec (
    .key (key),
    .sym (job_sym),
    .res (dot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= KEY_RESET;
    end else if (cfg_write) begin
      key <= cfg_data;
    end
  end

  // Open block and job register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      job_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (makes_job) begin
          fill_count <= '0;
        end else begin
          fill_count <= fill_count + FW'(1);
        end
      end
      if (accept && makes_job) begin
        job_valid <= 1'b1;
      end else if (job_move) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < BLOCK_SIZE - 1; k++) begin
        if (!makes_job && fill_count == FW'(k)) begin
          held[k] <= in_ch.symbol;
        end
      end
      if (makes_job) begin
        for (int k = 0; k < BLOCK_SIZE - 1; k++) begin
          job_sym[k] <= held[k];
        end
        job_sym[BLOCK_SIZE-1] <= in_ch.symbol;
        job_full              <= completes;
        job_last              <= fill_count;
      end
    end
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_idx   <= '0;
    end else if (job_move) begin
      run_valid <= 1'b1;
      run_idx   <= '0;
    end else if (out_take) begin
      if (run_at_last) begin
        run_valid <= 1'b0;
      end else begin
        run_idx <= run_idx + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_move) begin
      run_last <= job_last;
      for (int j = 0; j < BLOCK_SIZE; j++) begin
        run_val[j] <= job_full ? dot[j] : '0;
      end
    end
  end

endmodule

@@ hw/rtl/hbt_matvec.sv @@
// Key matrix times symbol block, each row reduced mod 25.
module hbt_matvec #(
  parameter int BLOCK_SIZE = hbt_pkg::BLOCK_SIZE
) (
  input  logic [hbt_pkg::KEY_W-1:0] key,
  input  logic [hbt_pkg::SYM_W-1:0] sym [BLOCK_SIZE],
  output logic [hbt_pkg::SYM_W-1:0] res [BLOCK_SIZE]
);
  import hbt_pkg::*;

  for (genvar j = 0; j < BLOCK_SIZE; j++) begin : g_row
    logic [SUM_W-1:0] acc;

    always_comb begin
      acc = '0;
      for (int k = 0; k < BLOCK_SIZE; k++) begin
        acc = acc + SUM_W'(sym[k]) * SUM_W'(key_digit(key, j, k));
      end
      res[j] = mod25(acc);
    end
  end

endmodule
